>>> hw/rtl/cpu_opcode_decoder_macros.svh
// assertion macros for the opcode decoder
// used by cpu_opcode_decoder.sv, no other dependencies
`ifndef CPU_OPCODE_DECODER_MACROS_SVH
`define CPU_OPCODE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define COD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cod assertion failed");

// next-cycle implication, checked outside reset
`define COD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cod assertion failed");

`endif

>>> hw/rtl/cod_pkg.sv
// types and handler code constants for the opcode decoder
// no dependencies
`timescale 1ns / 1ps

package cod_pkg;

    typedef logic [15:0] t_word;
    typedef logic [6:0]  t_handler_code;
    typedef logic [3:0]  t_vector;

    localparam t_handler_code HC_MOVEP     = 7'd0;
    localparam t_handler_code HC_BTST      = 7'd1;
    localparam t_handler_code HC_ORI       = 7'd5;
    localparam t_handler_code HC_ANDI      = 7'd6;
    localparam t_handler_code HC_SUBI      = 7'd7;
    localparam t_handler_code HC_ADDI      = 7'd8;
    localparam t_handler_code HC_EORI      = 7'd9;
    localparam t_handler_code HC_CMPI      = 7'd10;
    localparam t_handler_code HC_ILLEGAL   = 7'd11;
    localparam t_handler_code HC_MOVE      = 7'd12;
    localparam t_handler_code HC_MOVEA     = 7'd13;
    localparam t_handler_code HC_MOVE_FSR  = 7'd14;
    localparam t_handler_code HC_NEGX      = 7'd15;
    localparam t_handler_code HC_CLR       = 7'd16;
    localparam t_handler_code HC_MOVE_TCCR = 7'd17;
    localparam t_handler_code HC_NEG       = 7'd18;
    localparam t_handler_code HC_MOVE_TSR  = 7'd19;
    localparam t_handler_code HC_NOT       = 7'd20;
    localparam t_handler_code HC_NBCD      = 7'd21;
    localparam t_handler_code HC_SWAP      = 7'd22;
    localparam t_handler_code HC_PEA       = 7'd23;
    localparam t_handler_code HC_EXT       = 7'd24;
    localparam t_handler_code HC_MOVEM     = 7'd25;
    localparam t_handler_code HC_TAS       = 7'd26;
    localparam t_handler_code HC_TST       = 7'd27;
    localparam t_handler_code HC_TRAP      = 7'd28;
    localparam t_handler_code HC_UNLK      = 7'd29;
    localparam t_handler_code HC_LINK      = 7'd30;
    localparam t_handler_code HC_MOVE_USP  = 7'd31;
    localparam t_handler_code HC_RESET     = 7'd32;
    localparam t_handler_code HC_NOP       = 7'd33;
    localparam t_handler_code HC_STOP      = 7'd34;
    localparam t_handler_code HC_RTE       = 7'd35;
    localparam t_handler_code HC_RTS       = 7'd36;
    localparam t_handler_code HC_TRAPV     = 7'd37;
    localparam t_handler_code HC_RTR       = 7'd38;
    localparam t_handler_code HC_JSR       = 7'd39;
    localparam t_handler_code HC_JMP       = 7'd40;
    localparam t_handler_code HC_LEA       = 7'd41;
    localparam t_handler_code HC_CHK       = 7'd42;
    localparam t_handler_code HC_DBCC      = 7'd43;
    localparam t_handler_code HC_SCC       = 7'd44;
    localparam t_handler_code HC_SUBQ      = 7'd45;
    localparam t_handler_code HC_ADDQ      = 7'd46;
    localparam t_handler_code HC_BRA       = 7'd47;
    localparam t_handler_code HC_BSR       = 7'd48;
    localparam t_handler_code HC_BCC       = 7'd49;
    localparam t_handler_code HC_MOVEQ     = 7'd50;
    localparam t_handler_code HC_DIVS      = 7'd51;
    localparam t_handler_code HC_DIVU      = 7'd52;
    localparam t_handler_code HC_SBCD      = 7'd53;
    localparam t_handler_code HC_OR        = 7'd54;
    localparam t_handler_code HC_SUBA      = 7'd55;
    localparam t_handler_code HC_SUBX      = 7'd56;
    localparam t_handler_code HC_SUB       = 7'd57;
    localparam t_handler_code HC_LINE_A    = 7'd58;
    localparam t_handler_code HC_CMPA      = 7'd59;
    localparam t_handler_code HC_CMPM      = 7'd60;
    localparam t_handler_code HC_EOR       = 7'd61;
    localparam t_handler_code HC_CMP       = 7'd62;
    localparam t_handler_code HC_MULS      = 7'd63;
    localparam t_handler_code HC_MULU      = 7'd64;
    localparam t_handler_code HC_ABCD      = 7'd65;
    localparam t_handler_code HC_EXG       = 7'd66;
    localparam t_handler_code HC_AND       = 7'd67;
    localparam t_handler_code HC_ADDA      = 7'd68;
    localparam t_handler_code HC_ADDX      = 7'd69;
    localparam t_handler_code HC_ADD       = 7'd70;
    localparam t_handler_code HC_SHIFT_MEM = 7'd71;
    localparam t_handler_code HC_SHIFT_REG = 7'd75;
    localparam t_handler_code HC_LINE_F    = 7'd79;

    localparam t_vector VEC_NONE   = 4'd0;
    localparam t_vector VEC_LINE_A = 4'd10;
    localparam t_vector VEC_LINE_F = 4'd11;

endpackage

>>> hw/rtl/cod_ifs.sv
// valid/ready channel interfaces for the opcode decoder
// depends on cod_pkg
`timescale 1ns / 1ps

interface cod_instr_if;
    logic           valid;
    logic           ready;
    cod_pkg::t_word instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface cod_result_if;
    logic                   valid;
    logic                   ready;
    cod_pkg::t_handler_code handler_code;
    cod_pkg::t_vector       exception_vector;

    modport source (output valid, output handler_code, output exception_vector, input ready);
    modport sink   (input valid, input handler_code, input exception_vector, output ready);
endinterface

>>> hw/rtl/cpu_opcode_decoder.sv
// opcode decoder top level: input word register, decode logic, result register
// depends on cod_pkg, cod_ifs and cpu_opcode_decoder_macros.svh
//
// usage:
//   i_instr carries one 16-bit instruction word per handshake; o_result returns
//   the handler code (0 to 79, 11 for illegal) and the exception vector
//   (0 none, 10 line A, 11 line F) for each word, in order.
//   a word is taken when valid and ready are both high at a rising edge.
//   an accepted word passes from the input register through the decode logic
//   into the result register, where result valid rises and the result is
//   held until the receiver takes it.
//   throughput is one word per cycle while the receiver takes results.
//   when the receiver stalls, the result register holds its word and the input
//   register fills behind it; i_instr.ready drops once both are full and rises
//   in the same cycle the receiver takes the held result.
//   reset (i_rst_n low, synchronous) empties both registers; no result is
//   pending afterwards and i_instr.ready is high from the first cycle out of
//   reset. the block holds no other state.
`timescale 1ns / 1ps

`include "cpu_opcode_decoder_macros.svh"

module cpu_opcode_decoder (
    input logic         i_clk,
    input logic         i_rst_n,
    cod_instr_if.sink   i_instr,
    cod_result_if.source o_result
);
    import cod_pkg::*;

    logic          r_in_valid;
    t_word         r_word;
    logic          r_out_valid;
    t_handler_code r_hc;
    t_vector       r_vec;

    logic          out_load;
    logic          in_load;
    t_handler_code n_hc;
    t_vector       n_vec;

    function automatic t_handler_code dec_g0(input t_word w);
        t_handler_code hc;
        if (w[8] && w[5:3] == 3'b001) begin
            hc = HC_MOVEP;
        end else if (w[8]) begin
            hc = HC_BTST + t_handler_code'(w[7:6]);
        end else begin
            case (w[11:8])
                4'h0: hc = HC_ORI;
                4'h2: hc = HC_ANDI;
                4'h4: hc = HC_SUBI;
                4'h6: hc = HC_ADDI;
                4'h8: hc = HC_BTST + t_handler_code'(w[7:6]);
                4'hA: hc = HC_EORI;
                4'hC: hc = HC_CMPI;
                default: hc = HC_ILLEGAL;
            endcase
        end
        return hc;
    endfunction

    function automatic t_handler_code dec_g4e(input t_word w);
        t_handler_code hc;
        if (w[7]) begin
            hc = w[6] ? HC_JMP : HC_JSR;
        end else begin
            case (w[6:4])
                3'd4: hc = HC_TRAP;
                3'd5: hc = w[3] ? HC_UNLK : HC_LINK;
                3'd6: hc = HC_MOVE_USP;
                3'd7: begin
                    case (w[3:0])
                        4'd0: hc = HC_RESET;
                        4'd1: hc = HC_NOP;
                        4'd2: hc = HC_STOP;
                        4'd3: hc = HC_RTE;
                        4'd5: hc = HC_RTS;
                        4'd6: hc = HC_TRAPV;
                        4'd7: hc = HC_RTR;
                        default: hc = HC_ILLEGAL;
                    endcase
                end
                default: hc = HC_ILLEGAL;
            endcase
        end
        return hc;
    endfunction

    function automatic t_handler_code dec_g4(input t_word w);
        t_handler_code hc;
        logic          sz_w;
        logic          mode0;
        sz_w  = (w[7:6] == 2'b11);
        mode0 = (w[5:3] == 3'd0);
        case (w[11:8])
            4'h0: hc = sz_w ? HC_MOVE_FSR : HC_NEGX;
            4'h2: hc = HC_CLR;
            4'h4: hc = sz_w ? HC_MOVE_TCCR : HC_NEG;
            4'h6: hc = sz_w ? HC_MOVE_TSR : HC_NOT;
            4'h8: begin
                if (w[7:6] == 2'b00) begin
                    hc = HC_NBCD;
                end else if (w[7:6] == 2'b01) begin
                    hc = mode0 ? HC_SWAP : HC_PEA;
                end else begin
                    hc = mode0 ? HC_EXT : HC_MOVEM;
                end
            end
            4'hA: hc = sz_w ? HC_TAS : HC_TST;
            4'hC: hc = HC_MOVEM;
            4'hE: hc = dec_g4e(w);
            default: begin
                if (w[8:6] == 3'b111) begin
                    hc = HC_LEA;
                end else if (w[8:6] == 3'b110) begin
                    hc = HC_CHK;
                end else begin
                    hc = HC_ILLEGAL;
                end
            end
        endcase
        return hc;
    endfunction

    function automatic t_handler_code dec_gc(input t_word w);
        t_handler_code hc;
        logic [5:0]    m;
        m = w[8:3];
        if (w[7:6] == 2'b11) begin
            hc = w[8] ? HC_MULS : HC_MULU;
        end else if (w[8:4] == 5'b10000) begin
            hc = HC_ABCD;
        end else if (m == 6'b101000 || m == 6'b101001 || m == 6'b110001) begin
            hc = HC_EXG;
        end else begin
            hc = HC_AND;
        end
        return hc;
    endfunction

    always_comb begin
        n_vec = VEC_NONE;
        case (r_word[15:12])
            4'h0: n_hc = dec_g0(r_word);
            4'h1: n_hc = HC_MOVE;
            4'h2, 4'h3: n_hc = (r_word[8:6] == 3'd1) ? HC_MOVEA : HC_MOVE;
            4'h4: n_hc = dec_g4(r_word);
            4'h5: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = (r_word[5:3] == 3'b001) ? HC_DBCC : HC_SCC;
                end else begin
                    n_hc = r_word[8] ? HC_SUBQ : HC_ADDQ;
                end
            end
            4'h6: begin
                if (r_word[11:8] == 4'h0) begin
                    n_hc = HC_BRA;
                end else if (r_word[11:8] == 4'h1) begin
                    n_hc = HC_BSR;
                end else begin
                    n_hc = HC_BCC;
                end
            end
            4'h7: n_hc = HC_MOVEQ;
            4'h8: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = r_word[8] ? HC_DIVS : HC_DIVU;
                end else if (r_word[8:4] == 5'b10000) begin
                    n_hc = HC_SBCD;
                end else begin
                    n_hc = HC_OR;
                end
            end
            4'h9: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = HC_SUBA;
                end else if (r_word[8] && r_word[5:4] == 2'b00) begin
                    n_hc = HC_SUBX;
                end else begin
                    n_hc = HC_SUB;
                end
            end
            4'hA: begin
                n_hc  = HC_LINE_A;
                n_vec = VEC_LINE_A;
            end
            4'hB: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = HC_CMPA;
                end else if (r_word[8] && r_word[5:3] == 3'b001) begin
                    n_hc = HC_CMPM;
                end else if (r_word[8]) begin
                    n_hc = HC_EOR;
                end else begin
                    n_hc = HC_CMP;
                end
            end
            4'hC: n_hc = dec_gc(r_word);
            4'hD: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = HC_ADDA;
                end else if (r_word[8] && r_word[5:4] == 2'b00) begin
                    n_hc = HC_ADDX;
                end else begin
                    n_hc = HC_ADD;
                end
            end
            4'hE: begin
                if (r_word[7:6] == 2'b11) begin
                    n_hc = HC_SHIFT_MEM + t_handler_code'(r_word[10:9]);
                end else begin
                    n_hc = HC_SHIFT_REG + t_handler_code'(r_word[4:3]);
                end
            end
            default: begin
                n_hc  = HC_LINE_F;
                n_vec = VEC_LINE_F;
            end
        endcase
    end

    // input register holds a word and result register free or being emptied this cycle
    assign out_load      = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_load       = i_instr.valid && i_instr.ready;
    assign i_instr.ready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_word <= i_instr.instruction_word;
        end
        if (out_load) begin
            r_hc  <= n_hc;
            r_vec <= n_vec;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.handler_code     = r_hc;
    assign o_result.exception_vector = r_vec;

    `COD_ASSERT_IMPL(a_line_f_code, i_clk, i_rst_n, r_out_valid && r_vec == VEC_LINE_F, r_hc == HC_LINE_F)
    `COD_ASSERT_IMPL(a_code_range, i_clk, i_rst_n, r_out_valid, r_hc <= HC_LINE_F)
    `COD_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !out_load, r_in_valid && $stable(r_word))
    `COD_ASSERT_NEXT(a_in_fill, i_clk, i_rst_n, in_load, r_in_valid)
    `COD_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, out_load, r_out_valid)

endmodule
